/* hw/rtl/afes_pkg.sv */
`timescale 1ns / 1ps

package afes_pkg;

  localparam int FRACTION_BITS = 15;
  localparam logic [15:0] ONE = 16'(1 << FRACTION_BITS);
  localparam logic [15:0] NEUTRAL_RMS = 16'((1 << FRACTION_BITS) / 4);
  localparam logic [15:0] NEUTRAL_LOW = 16'((4 * (1 << FRACTION_BITS) + 5) / 10);
  localparam logic [15:0] NEUTRAL_HIGH = 16'((3 * (1 << FRACTION_BITS) + 5) / 10);
  localparam logic [14:0] DT_MAX = 15'd16384;

  localparam int NUM_W = 34;
  localparam int DEN_W = 20;
  localparam int CNT_W = 6;
  localparam int NUM_CH = 10;
  localparam int STEP_W = 5;

  localparam logic [2:0] CFG_LOW_GAIN = 3'd0;
  localparam logic [2:0] CFG_MID_GAIN = 3'd1;
  localparam logic [2:0] CFG_HIGH_GAIN = 3'd2;
  localparam logic [2:0] CFG_TRANS_GAIN = 3'd3;
  localparam logic [2:0] CFG_REACTION = 3'd4;
  localparam logic [2:0] CFG_SMOOTHING = 3'd5;

  typedef struct packed {
    logic [15:0] rms_level;
    logic [15:0] peak_level;
    logic [15:0] low_energy;
    logic [15:0] mid_energy;
    logic [15:0] high_energy;
    logic [15:0] low_transient;
    logic [15:0] mid_transient;
    logic [15:0] high_transient;
    logic [15:0] spectral_centroid;
    logic [15:0] stereo_width;
    logic        is_silent;
    logic [14:0] frame_time;
  } in_item_t;

  typedef struct packed {
    logic [15:0] smooth_rms;
    logic [15:0] smooth_peak;
    logic [15:0] smooth_low;
    logic [15:0] smooth_mid;
    logic [15:0] smooth_high;
    logic [15:0] held_low_transient;
    logic [15:0] held_mid_transient;
    logic [15:0] held_high_transient;
    logic [15:0] transient_likelihood;
    logic [15:0] smooth_centroid;
    logic [15:0] smooth_width;
    logic        silent_out;
  } out_item_t;

  typedef enum logic [3:0] {
    CH_RMS, CH_PEAK, CH_LOW, CH_MID, CH_HIGH,
    CH_TLOW, CH_TMID, CH_THIGH, CH_CENT, CH_WIDTH
  } ch_t;

  typedef enum logic [1:0] {
    SH_GAIN, SH_REACT, SH_COEFF
  } shift_t;

  typedef enum logic [2:0] {
    K_SCALE_G, K_SCALE_R, K_SHAPE, K_BLEND, K_DECAY
  } kind_t;

  typedef struct packed {
    kind_t kind;
    ch_t   ch;
    logic  use_t;
    logic  last;
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_ISSUE, ST_WAIT, ST_WB, ST_FINISH
  } state_t;

  function automatic op_t mk_op(kind_t kind, ch_t ch, logic use_t, logic last);
    op_t o;
    o.kind = kind;
    o.ch = ch;
    o.use_t = use_t;
    o.last = last;
    return o;
  endfunction

  // Micro-program: most targets are built in the temp, then folded into the state.
  function automatic op_t op_rom(logic [STEP_W-1:0] step);
    op_t o;
    unique case (step)
      5'd0:  o = mk_op(K_SHAPE, CH_RMS, 1'b0, 1'b0);
      5'd1:  o = mk_op(K_BLEND, CH_RMS, 1'b1, 1'b0);
      5'd2:  o = mk_op(K_BLEND, CH_PEAK, 1'b0, 1'b0);
      5'd3:  o = mk_op(K_SCALE_G, CH_LOW, 1'b0, 1'b0);
      5'd4:  o = mk_op(K_SHAPE, CH_LOW, 1'b1, 1'b0);
      5'd5:  o = mk_op(K_BLEND, CH_LOW, 1'b1, 1'b0);
      5'd6:  o = mk_op(K_SCALE_G, CH_MID, 1'b0, 1'b0);
      5'd7:  o = mk_op(K_SHAPE, CH_MID, 1'b1, 1'b0);
      5'd8:  o = mk_op(K_BLEND, CH_MID, 1'b1, 1'b0);
      5'd9:  o = mk_op(K_SCALE_G, CH_HIGH, 1'b0, 1'b0);
      5'd10: o = mk_op(K_SHAPE, CH_HIGH, 1'b1, 1'b0);
      5'd11: o = mk_op(K_BLEND, CH_HIGH, 1'b1, 1'b0);
      5'd12: o = mk_op(K_SCALE_G, CH_TLOW, 1'b0, 1'b0);
      5'd13: o = mk_op(K_SCALE_R, CH_TLOW, 1'b1, 1'b0);
      5'd14: o = mk_op(K_DECAY, CH_TLOW, 1'b1, 1'b0);
      5'd15: o = mk_op(K_SCALE_G, CH_TMID, 1'b0, 1'b0);
      5'd16: o = mk_op(K_SCALE_R, CH_TMID, 1'b1, 1'b0);
      5'd17: o = mk_op(K_DECAY, CH_TMID, 1'b1, 1'b0);
      5'd18: o = mk_op(K_SCALE_G, CH_THIGH, 1'b0, 1'b0);
      5'd19: o = mk_op(K_SCALE_R, CH_THIGH, 1'b1, 1'b0);
      5'd20: o = mk_op(K_DECAY, CH_THIGH, 1'b1, 1'b0);
      5'd21: o = mk_op(K_BLEND, CH_CENT, 1'b0, 1'b0);
      default: o = mk_op(K_BLEND, CH_WIDTH, 1'b0, 1'b1);
    endcase
    return o;
  endfunction

endpackage

/* hw/rtl/audio_feature_envelope_shaper_top.sv */
`timescale 1ns / 1ps
// Audio feature envelope shaper.
// A request on the in_ channel carries one analysis frame of audio features;
// each one produces exactly one smoothed frame on the out_ channel. Both use
// valid/ready. Registers are written through the cfg_ channel (index, data),
// which is always ready and should only be used while the block is idle.
// Per frame, a serial divider first forms the smoothing coefficient (34 quotient
// bits, one per cycle), and the result is stored in the coefficient register.
// A sequencer then runs 23 operations through one shared multiply, round and
// clamp unit, each passing through the issue, wait and write-back states, and
// then loads the output register. in_ready is low from acceptance until then
// and rises together with out_valid, so a new frame is accepted only once the
// last result is in the output register. The result sits in an output
// register; a stalled receiver holds it there, and the next frame's result
// waits until it is taken. Reset restores the register defaults and clears all
// smoothed channel state to zero.

module audio_feature_envelope_shaper_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  afes_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output afes_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  afes_pkg::state_t    state_r, state_nxt;
  logic [15:0]         low_gain_r, mid_gain_r, high_gain_r, trans_gain_r;
  logic [15:0]         reaction_r, smoothing_r;
  afes_pkg::in_item_t  in_r;
  afes_pkg::out_item_t out_r;
  logic                out_valid_r;
  logic [15:0]         ch_r [afes_pkg::NUM_CH];
  logic [15:0]         t_r;
  logic [15:0]         coeff_r;
  logic [afes_pkg::STEP_W-1:0] step_r;

  logic                in_fire, div_busy, issue, load_out;
  logic [15:0]         r_w, s_w, x_w, src_w, cur_w, gain_w, neutral_w;
  logic [14:0]         dt_w;
  logic [18:0]         dt25_w;
  logic [afes_pkg::NUM_W-1:0] num_w, quo_w;
  logic [afes_pkg::DEN_W-1:0] den_w;
  afes_pkg::op_t       op_w;
  logic signed [17:0]  a_w;
  logic [15:0]         b_w, base_w, res_w, lik_w;
  afes_pkg::shift_t    sh_w;

  assign cfg_ready = 1'b1;
  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_gain_r <= 16'd8192;
      mid_gain_r <= 16'd8192;
      high_gain_r <= 16'd8192;
      trans_gain_r <= 16'd8192;
      reaction_r <= 16'd16384;
      smoothing_r <= 16'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        afes_pkg::CFG_LOW_GAIN:   low_gain_r <= cfg_data;
        afes_pkg::CFG_MID_GAIN:   mid_gain_r <= cfg_data;
        afes_pkg::CFG_HIGH_GAIN:  high_gain_r <= cfg_data;
        afes_pkg::CFG_TRANS_GAIN: trans_gain_r <= cfg_data;
        afes_pkg::CFG_REACTION:   reaction_r <= cfg_data;
        afes_pkg::CFG_SMOOTHING:  smoothing_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign r_w = (reaction_r > afes_pkg::ONE) ? afes_pkg::ONE : reaction_r;
  assign s_w = (smoothing_r > afes_pkg::ONE) ? afes_pkg::ONE : smoothing_r;

  // coeff = (dt * 25 * 2^15 + den / 2) / den with den = 2^15 + 24 * s.
  assign dt_w = (in_data.frame_time > afes_pkg::DT_MAX) ? afes_pkg::DT_MAX
                                                         : in_data.frame_time;
  assign dt25_w = {dt_w, 4'b0} + {1'b0, dt_w, 3'b0} + {4'b0, dt_w};
  assign den_w = 20'd32768 + {s_w, 4'b0} + {1'b0, s_w, 3'b0};
  assign num_w = {dt25_w, 15'b0} + 34'd16384
               + 34'({s_w, 3'b0}) + 34'({s_w, 2'b0});

  afes_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (in_fire),
    .num_i   (num_w),
    .den_i   (den_w),
    .busy_o  (div_busy),
    .quo_o   (quo_w)
  );

  // Operand selection for the current micro-operation.
  always_comb begin
    op_w = afes_pkg::op_rom(step_r);
    unique case (op_w.ch)
      afes_pkg::CH_RMS:   x_w = in_r.rms_level;
      afes_pkg::CH_PEAK:  x_w = in_r.peak_level;
      afes_pkg::CH_LOW:   x_w = in_r.low_energy;
      afes_pkg::CH_MID:   x_w = in_r.mid_energy;
      afes_pkg::CH_HIGH:  x_w = in_r.high_energy;
      afes_pkg::CH_TLOW:  x_w = in_r.low_transient;
      afes_pkg::CH_TMID:  x_w = in_r.mid_transient;
      afes_pkg::CH_THIGH: x_w = in_r.high_transient;
      afes_pkg::CH_CENT:  x_w = in_r.spectral_centroid;
      default:            x_w = in_r.stereo_width;
    endcase
    if (x_w > afes_pkg::ONE) begin
      x_w = afes_pkg::ONE;
    end
    unique case (op_w.ch)
      afes_pkg::CH_LOW:  gain_w = low_gain_r;
      afes_pkg::CH_MID:  gain_w = mid_gain_r;
      afes_pkg::CH_HIGH: gain_w = high_gain_r;
      default:           gain_w = trans_gain_r;
    endcase
    unique case (op_w.ch)
      afes_pkg::CH_RMS:  neutral_w = afes_pkg::NEUTRAL_RMS;
      afes_pkg::CH_HIGH: neutral_w = afes_pkg::NEUTRAL_HIGH;
      default:           neutral_w = afes_pkg::NEUTRAL_LOW;
    endcase
    src_w = op_w.use_t ? t_r : x_w;
    cur_w = ch_r[op_w.ch];
    unique case (op_w.kind)
      afes_pkg::K_SCALE_G: begin
        a_w = $signed({2'b0, src_w});
        b_w = gain_w;
        base_w = 16'd0;
        sh_w = afes_pkg::SH_GAIN;
      end
      afes_pkg::K_SCALE_R: begin
        a_w = $signed({2'b0, src_w});
        b_w = r_w;
        base_w = 16'd0;
        sh_w = afes_pkg::SH_REACT;
      end
      afes_pkg::K_SHAPE: begin
        a_w = $signed({2'b0, src_w}) - $signed({2'b0, neutral_w});
        b_w = r_w;
        base_w = neutral_w;
        sh_w = afes_pkg::SH_REACT;
      end
      afes_pkg::K_BLEND: begin
        a_w = $signed({2'b0, src_w}) - $signed({2'b0, cur_w});
        b_w = coeff_r;
        base_w = cur_w;
        sh_w = afes_pkg::SH_COEFF;
      end
      default: begin
        a_w = -$signed({2'b0, cur_w});
        b_w = coeff_r;
        base_w = cur_w;
        sh_w = afes_pkg::SH_COEFF;
      end
    endcase
  end

  afes_mac u_mac (
    .clk     (clk),
    .issue_i (issue),
    .a_i     (a_w),
    .b_i     (b_w),
    .base_i  (base_w),
    .sh_i    (sh_w),
    .res_o   (res_w)
  );

  always_comb begin
    state_nxt = state_r;
    in_ready = 1'b0;
    issue = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      afes_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = afes_pkg::ST_DIV;
        end
      end
      afes_pkg::ST_DIV: begin
        if (!div_busy) begin
          state_nxt = afes_pkg::ST_ISSUE;
        end
      end
      afes_pkg::ST_ISSUE: begin
        issue = 1'b1;
        state_nxt = afes_pkg::ST_WAIT;
      end
      afes_pkg::ST_WAIT: state_nxt = afes_pkg::ST_WB;
      afes_pkg::ST_WB: begin
        state_nxt = op_w.last ? afes_pkg::ST_FINISH : afes_pkg::ST_ISSUE;
      end
      afes_pkg::ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          load_out = 1'b1;
          state_nxt = afes_pkg::ST_IDLE;
        end
      end
      default: state_nxt = afes_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= afes_pkg::ST_IDLE;
      step_r <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < afes_pkg::NUM_CH; i++) begin
        ch_r[i] <= 16'd0;
      end
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        step_r <= '0;
      end else if (state_r == afes_pkg::ST_WB) begin
        step_r <= step_r + 1'b1;
        if (op_w.kind == afes_pkg::K_BLEND) begin
          ch_r[op_w.ch] <= res_w;
        end else if (op_w.kind == afes_pkg::K_DECAY) begin
          ch_r[op_w.ch] <= (t_r > res_w) ? t_r : res_w;
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign lik_w = (ch_r[afes_pkg::CH_TMID] > ch_r[afes_pkg::CH_TLOW])
               ? ((ch_r[afes_pkg::CH_THIGH] > ch_r[afes_pkg::CH_TMID])
                  ? ch_r[afes_pkg::CH_THIGH] : ch_r[afes_pkg::CH_TMID])
               : ((ch_r[afes_pkg::CH_THIGH] > ch_r[afes_pkg::CH_TLOW])
                  ? ch_r[afes_pkg::CH_THIGH] : ch_r[afes_pkg::CH_TLOW]);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_r <= in_data;
    end
    if (state_r == afes_pkg::ST_DIV && !div_busy) begin
      coeff_r <= (quo_w > afes_pkg::NUM_W'(afes_pkg::ONE)) ? afes_pkg::ONE : quo_w[15:0];
    end
    if (state_r == afes_pkg::ST_WB && (op_w.kind == afes_pkg::K_SCALE_G ||
        op_w.kind == afes_pkg::K_SCALE_R || op_w.kind == afes_pkg::K_SHAPE)) begin
      t_r <= res_w;
    end
    if (load_out) begin
      out_r.smooth_rms <= ch_r[afes_pkg::CH_RMS];
      out_r.smooth_peak <= ch_r[afes_pkg::CH_PEAK];
      out_r.smooth_low <= ch_r[afes_pkg::CH_LOW];
      out_r.smooth_mid <= ch_r[afes_pkg::CH_MID];
      out_r.smooth_high <= ch_r[afes_pkg::CH_HIGH];
      out_r.held_low_transient <= ch_r[afes_pkg::CH_TLOW];
      out_r.held_mid_transient <= ch_r[afes_pkg::CH_TMID];
      out_r.held_high_transient <= ch_r[afes_pkg::CH_THIGH];
      out_r.transient_likelihood <= lik_w;
      out_r.smooth_centroid <= ch_r[afes_pkg::CH_CENT];
      out_r.smooth_width <= ch_r[afes_pkg::CH_WIDTH];
      out_r.silent_out <= in_r.is_silent;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

endmodule

/* hw/rtl/afes_div.sv */
`timescale 1ns / 1ps

module afes_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start_i,
  input  logic [afes_pkg::NUM_W-1:0]   num_i,
  input  logic [afes_pkg::DEN_W-1:0]   den_i,
  output logic                         busy_o,
  output logic [afes_pkg::NUM_W-1:0]   quo_o
);

  logic                        busy_r;
  logic [afes_pkg::CNT_W-1:0]  cnt_r;
  logic [afes_pkg::NUM_W-1:0]  q_r;
  logic [afes_pkg::DEN_W-1:0]  rem_r;
  logic [afes_pkg::DEN_W-1:0]  den_r;
  logic [afes_pkg::DEN_W:0]    trial_w;
  logic                        fit_w;

  assign trial_w = {rem_r, q_r[afes_pkg::NUM_W-1]};
  assign fit_w = trial_w >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else if (start_i) begin
      busy_r <= 1'b1;
      cnt_r <= afes_pkg::CNT_W'(afes_pkg::NUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == afes_pkg::CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Restoring division, one quotient bit per cycle; quotient bits replace the numerator.
  always_ff @(posedge clk) begin
    if (start_i) begin
      q_r <= num_i;
      rem_r <= '0;
      den_r <= den_i;
    end else if (busy_r) begin
      q_r <= {q_r[afes_pkg::NUM_W-2:0], fit_w};
      rem_r <= fit_w ? afes_pkg::DEN_W'(trial_w - {1'b0, den_r})
                     : trial_w[afes_pkg::DEN_W-1:0];
    end
  end

  assign busy_o = busy_r;
  assign quo_o = q_r;

endmodule

/* hw/rtl/afes_mac.sv */
`timescale 1ns / 1ps

module afes_mac (
  input  logic                    clk,
  input  logic                    issue_i,
  input  logic signed [17:0]      a_i,
  input  logic [15:0]             b_i,
  input  logic [15:0]             base_i,
  input  afes_pkg::shift_t        sh_i,
  output logic [15:0]             res_o
);

  logic signed [34:0]  prod_r;
  logic [15:0]         base_r;
  afes_pkg::shift_t    sh_r;
  logic [15:0]         res_r;
  logic                neg_w;
  logic [35:0]         mag_w;
  logic [35:0]         rnd_w;
  logic signed [37:0]  sum_w;
  logic signed [37:0]  term_w;

  always_ff @(posedge clk) begin
    if (issue_i) begin
      prod_r <= a_i * $signed({1'b0, b_i});
      base_r <= base_i;
      sh_r <= sh_i;
    end
    res_r <= (sum_w < 0) ? 16'd0 :
             (sum_w > $signed({22'b0, afes_pkg::ONE})) ? afes_pkg::ONE : sum_w[15:0];
  end

  // Shift rounded half away from zero, then add the base and clamp to [0, 1].
  always_comb begin
    neg_w = prod_r[34];
    mag_w = neg_w ? 36'(-{prod_r[34], prod_r}) : {1'b0, prod_r};
    unique case (sh_r)
      afes_pkg::SH_GAIN:  rnd_w = (mag_w + 36'd4096) >> 13;
      afes_pkg::SH_REACT: rnd_w = (mag_w + 36'd8192) >> 14;
      afes_pkg::SH_COEFF: rnd_w = (mag_w + 36'd16384) >> 15;
      default:            rnd_w = (mag_w + 36'd16384) >> 15;
    endcase
    term_w = neg_w ? -$signed({2'b0, rnd_w}) : $signed({2'b0, rnd_w});
    sum_w = $signed({22'b0, base_r}) + term_w;
  end

  assign res_o = res_r;

endmodule
